// ===== hdl/axdz_pkg.sv =====
// ----------------------------------------------------------------------------
// axdz_pkg
// Shared types and constants for the axis dead-zone remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package axdz_pkg;

	localparam logic [1:0] MODE_BUTTON = 2'd0;
	localparam logic [1:0] MODE_AXIS1D = 2'd1;
	localparam logic [1:0] MODE_AXIS2D = 2'd2;
	localparam logic [1:0] MODE_AXIS3D = 2'd3;

	localparam logic WR_INNER = 1'b0;
	localparam logic WR_OUTER = 1'b1;

	localparam logic [14:0] FULL_SCALE = 15'd16384;

	localparam int SQ_FIRST    = 2;
	localparam int SQ_LAST     = 9;
	localparam int ST_RINIT    = 10;
	localparam int RD_FIRST    = 11;
	localparam int RD_LAST     = 17;
	localparam int ST_MUL      = 18;
	localparam int RT_FIRST    = 19;
	localparam int RT_LAST     = 27;
	localparam int NST         = 27;
	localparam int STEPS_PER   = 2;
	localparam int RATIO_STEPS = 17;

	typedef struct packed {
		logic        zero;
		logic        pass;
		logic        sat;
		logic [16:0] mag;
		logic [15:0] rem;
		logic [13:0] q;
	} lane_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              btn;
		logic              sgx;
		logic              sgy;
		logic              sgz;
		logic [16:0]       ax;
		logic [16:0]       ay;
		logic [16:0]       az;
		logic [31:0]       sq_n;
		logic [31:0]       sq_r;
		logic [15:0]       rad;
		lane_t [2:0]       ln;
		logic [2:0][16:0]  rm;
		logic              rzero;
		logic [1:0][16:0]  dnum;
		logic [1:0][15:0]  drem;
		logic [1:0][16:0]  dq;
	} pipe_t;

endpackage

`default_nettype wire

// ===== hdl/axis_dead_zone_remap_core.sv =====
// ----------------------------------------------------------------------------
// axis_dead_zone_remap_core
// Scaled dead zone: radial on 2D sticks, per axis on 1D/3D, buttons passed.
// ----------------------------------------------------------------------------
// Each accepted beat passes through every stage register, then the output register.
// Throughput is one beat per cycle unless the output stalls; the stick square root
// (two bits a stage), the zone divider and the ratio divider are all fully pipelined.
// The whole pipeline advances together and halts only when the output is stalled.
// Reset clears all valid bits and loads the zones with 0 and 1.0.
`default_nettype none

module axis_dead_zone_remap_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [14:0] wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  mode,
	input  wire logic [15:0] axis_x,
	input  wire logic [15:0] axis_y,
	input  wire logic [15:0] axis_z,
	input  wire logic        button,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       out_mode,
	output logic [15:0]      out_x,
	output logic [15:0]      out_y,
	output logic [15:0]      out_z,
	output logic             out_button
);
	import axdz_pkg::*;

	logic [14:0] zone_inner_q;
	logic [14:0] zone_outer_q;
	logic [14:0] lo;
	logic [14:0] hi;
	logic [14:0] dz;
	logic        adv;

	pipe_t pipe_s [1:NST];
	logic  vld_s  [1:NST];
	pipe_t nxt    [2:NST];
	pipe_t pipe_in;

	logic [15:0] res_x;
	logic [15:0] res_y;
	logic [15:0] res_z;
	logic        res_button;

	function automatic logic [16:0] mag17(input logic [15:0] v);
		logic [16:0] e;
		e = {v[15], v};
		return v[15] ? 17'(-e) : e;
	endfunction

	function automatic logic [15:0] apply_sign(input logic s, input logic [16:0] m);
		logic [16:0] r;
		r = s ? 17'(-m) : m;
		return r[15:0];
	endfunction

	function automatic pipe_t sqrt_step(input pipe_t p, input int j);
		pipe_t       o;
		logic [31:0] b;
		logic [31:0] t;
		o = p;
		b = 32'h4000_0000 >> (2 * j);
		t = p.sq_r + b;
		if (p.sq_n >= t) begin
			o.sq_n = p.sq_n - t;
			o.sq_r = (p.sq_r >> 1) + b;
		end else begin
			o.sq_r = p.sq_r >> 1;
		end
		return o;
	endfunction

	function automatic lane_t lane_init(input logic [16:0] m, input logic [14:0] l,
			input logic [14:0] h, input logic [14:0] d);
		lane_t       o;
		logic [16:0] n;
		n = m - {2'b00, l};
		o.zero = (m <= {2'b00, l});
		o.pass = (h <= l);
		o.sat  = (n >= {2'b00, d});
		o.mag  = m;
		o.rem  = n[15:0];
		o.q    = '0;
		return o;
	endfunction

	function automatic lane_t lane_step(input lane_t p, input logic [14:0] d);
		lane_t       o;
		logic [16:0] r2;
		o = p;
		r2 = {p.rem, 1'b0};
		if (r2 >= {2'b00, d}) begin
			o.rem = 16'(r2 - {2'b00, d});
			o.q   = {p.q[12:0], 1'b1};
		end else begin
			o.rem = r2[15:0];
			o.q   = {p.q[12:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [16:0] lane_value(input lane_t p);
		if (p.zero) begin
			return '0;
		end else if (p.pass) begin
			return p.mag;
		end else if (p.sat) begin
			return {2'b00, FULL_SCALE};
		end
		return {3'b000, p.q};
	endfunction

	function automatic pipe_t mul_stage(input pipe_t p);
		pipe_t       o;
		logic [33:0] px;
		logic [33:0] py;
		o = p;
		for (int c = 0; c < 3; c++) begin
			o.rm[c] = lane_value(p.ln[c]);
		end
		o.rzero   = (p.rad == '0) || (o.rm[0] == '0);
		px        = p.ax * o.rm[0];
		py        = p.ay * o.rm[0];
		o.drem[0] = {1'b0, px[31:17]};
		o.dnum[0] = px[16:0];
		o.drem[1] = {1'b0, py[31:17]};
		o.dnum[1] = py[16:0];
		o.dq      = '0;
		return o;
	endfunction

	function automatic pipe_t ratio_step(input pipe_t p);
		pipe_t       o;
		logic [16:0] r2;
		o = p;
		for (int c = 0; c < 2; c++) begin
			r2        = {p.drem[c], p.dnum[c][16]};
			o.dnum[c] = {p.dnum[c][15:0], 1'b0};
			if (r2 >= {1'b0, p.rad}) begin
				o.drem[c] = 16'(r2 - {1'b0, p.rad});
				o.dq[c]   = {p.dq[c][15:0], 1'b1};
			end else begin
				o.drem[c] = r2[15:0];
				o.dq[c]   = {p.dq[c][15:0], 1'b0};
			end
		end
		return o;
	endfunction

	assign lo       = (zone_inner_q > FULL_SCALE) ? FULL_SCALE : zone_inner_q;
	assign hi       = (zone_outer_q > FULL_SCALE) ? FULL_SCALE : zone_outer_q;
	assign dz       = hi - lo;
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_inner_q <= '0;
			zone_outer_q <= FULL_SCALE;
		end else if (wr_en) begin
			if (wr_index == WR_OUTER) begin
				zone_outer_q <= wr_data;
			end else begin
				zone_inner_q <= wr_data;
			end
		end
	end

	always_comb begin
		pipe_in      = '0;
		pipe_in.mode = mode;
		pipe_in.btn  = button;
		pipe_in.sgx  = axis_x[15];
		pipe_in.sgy  = axis_y[15];
		pipe_in.sgz  = axis_z[15];
		pipe_in.ax   = mag17(axis_x);
		pipe_in.ay   = mag17(axis_y);
		pipe_in.az   = mag17(axis_z);
		pipe_in.sq_n = 32'($signed(axis_x) * $signed(axis_x))
			+ 32'($signed(axis_y) * $signed(axis_y));
	end

	always_comb begin
		pipe_t p;
		int    j;
		for (int k = 2; k <= NST; k++) begin
			p = pipe_s[k-1];
			if (k >= SQ_FIRST && k <= SQ_LAST) begin
				for (int i = 0; i < STEPS_PER; i++) begin
					p = sqrt_step(p, (k - SQ_FIRST) * STEPS_PER + i);
				end
			end else if (k == ST_RINIT) begin
				p.rad   = p.sq_r[15:0];
				p.ln[0] = lane_init((p.mode == MODE_AXIS2D) ? p.sq_r[16:0] : p.ax,
					lo, hi, dz);
				p.ln[1] = lane_init(p.ay, lo, hi, dz);
				p.ln[2] = lane_init(p.az, lo, hi, dz);
			end else if (k >= RD_FIRST && k <= RD_LAST) begin
				for (int i = 0; i < STEPS_PER; i++) begin
					for (int c = 0; c < 3; c++) begin
						p.ln[c] = lane_step(p.ln[c], dz);
					end
				end
			end else if (k == ST_MUL) begin
				p = mul_stage(p);
			end else if (k >= RT_FIRST && k <= RT_LAST) begin
				for (int i = 0; i < STEPS_PER; i++) begin
					j = (k - RT_FIRST) * STEPS_PER + i;
					if (j < RATIO_STEPS) begin
						p = ratio_step(p);
					end
				end
			end
			nxt[k] = p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) begin
				vld_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
			out_valid <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_s[1] <= pipe_in;
			for (int k = 2; k <= NST; k++) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	always_comb begin
		res_x      = '0;
		res_y      = '0;
		res_z      = '0;
		res_button = 1'b0;
		unique case (pipe_s[NST].mode)
			MODE_BUTTON: begin
				res_button = pipe_s[NST].btn;
			end
			MODE_AXIS1D: begin
				res_x = apply_sign(pipe_s[NST].sgx, pipe_s[NST].rm[0]);
			end
			MODE_AXIS2D: begin
				if (!pipe_s[NST].rzero) begin
					res_x = apply_sign(pipe_s[NST].sgx, pipe_s[NST].dq[0]);
					res_y = apply_sign(pipe_s[NST].sgy, pipe_s[NST].dq[1]);
				end
			end
			MODE_AXIS3D: begin
				res_x = apply_sign(pipe_s[NST].sgx, pipe_s[NST].rm[0]);
				res_y = apply_sign(pipe_s[NST].sgy, pipe_s[NST].rm[1]);
				res_z = apply_sign(pipe_s[NST].sgz, pipe_s[NST].rm[2]);
			end
			default: begin
				res_button = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_mode   <= pipe_s[NST].mode;
			out_x      <= res_x;
			out_y      <= res_y;
			out_z      <= res_z;
			out_button <= res_button;
		end
	end

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	a_button_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_mode == MODE_BUTTON) |-> (out_x == '0 && out_y == '0 && out_z == '0))
		else $error("button beat carries axis data");

	a_no_button: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_mode != MODE_BUTTON) |-> !out_button)
		else $error("axis beat carries button");

	a_axis1d_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_mode == MODE_AXIS1D) |-> (out_y == '0 && out_z == '0))
		else $error("1D beat carries y or z");

endmodule

`default_nettype wire
